[src/lce_pkg.sv]
// Shared types, constants and helper functions for the link cost estimator.
// Used by the controller, the datapath, the divider and the top level.
package lce_pkg;

    localparam int LCE_ENTRIES = 16;

    localparam int COST_W  = 16;
    localparam int COEF_W  = 11;
    localparam int ENTRY_W = 4;
    localparam int ACT_W   = 2;
    localparam int PROD_W  = COEF_W + COST_W;
    localparam int DIV_W   = PROD_W + 1;
    localparam int DVS_W   = 16;
    localparam int OP_W    = 3;

    localparam logic [COST_W-1:0] COST_INIT     = 16'd256;
    localparam logic [COST_W-1:0] COST_SENTINEL = 16'hffff;

    localparam logic [COEF_W-1:0] SCALE_RESET     = 11'd256;
    localparam logic [COEF_W-1:0] ALPHA_RESET     = 11'd32;
    localparam logic [COST_W-1:0] THRESHOLD_RESET = 16'd3;
    localparam logic [COST_W-1:0] CEILING_RESET   = 16'd1024;

    localparam logic [1:0] REG_SCALE     = 2'd0;
    localparam logic [1:0] REG_ALPHA     = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_CEILING   = 2'd3;

    localparam logic [ACT_W-1:0] ACT_INIT    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REQUEST = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ACCEPT  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_UPDATE  = 2'd3;

    localparam logic [OP_W-1:0] OP_NONE      = 3'd0;
    localparam logic [OP_W-1:0] OP_MUL_RATIO = 3'd1;
    localparam logic [OP_W-1:0] OP_DIV_RATIO = 3'd2;
    localparam logic [OP_W-1:0] OP_SAMPLE    = 3'd3;
    localparam logic [OP_W-1:0] OP_MUL_MIX   = 3'd4;
    localparam logic [OP_W-1:0] OP_DIV_MIX   = 3'd5;
    localparam logic [OP_W-1:0] OP_MIX_DONE  = 3'd6;
    localparam logic [OP_W-1:0] OP_COMMIT    = 3'd7;

    typedef struct packed {
        logic            load;
        logic [OP_W-1:0] op;
    } lce_cmd_t;

    typedef struct packed {
        logic go_update;
        logic acc_zero;
        logic old_sentinel;
        logic div_done;
        logic div_busy;
        logic out_free;
    } lce_status_t;

    function automatic logic [COST_W-1:0] sat_inc(input logic [COST_W-1:0] v);
        logic [COST_W:0] sum;
        sum = {1'b0, v} + {{COST_W{1'b0}}, 1'b1};
        sat_inc = sum[COST_W] ? COST_SENTINEL : sum[COST_W-1:0];
    endfunction

    function automatic logic [COST_W-1:0] sat_quot(input logic [DIV_W-1:0] q);
        sat_quot = (|q[DIV_W-1:COST_W]) ? COST_SENTINEL : q[COST_W-1:0];
    endfunction

endpackage

[src/lce_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, shared by both divisions.
// Depends on lce_pkg for operand widths.
module lce_div
    import lce_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic             busy,
    output logic             done
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic [DIV_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

[src/lce_datapath.sv]
// Datapath: configuration registers, neighbor tables, multipliers and output register.
// Depends on lce_pkg and instantiates lce_div; driven by commands from lce_ctrl.
module lce_datapath
    import lce_pkg::*;
#(
    parameter int ENTRIES = LCE_ENTRIES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  lce_cmd_t           cmd,
    output lce_status_t        status,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic [ACT_W-1:0]   in_action,
    input  logic [ENTRY_W-1:0] in_entry,
    input  logic               m_axis_tready,
    output logic               m_axis_tvalid,
    output logic [47:0]        m_axis_tdata,
    output logic [0:0]         m_axis_tuser
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [8:0] ENT_LIM = 9'(ENTRIES);

    logic [COEF_W-1:0] scale_reg;
    logic [COEF_W-1:0] alpha_reg;
    logic [COST_W-1:0] threshold_reg;
    logic [COST_W-1:0] ceiling_reg;

    logic [COST_W-1:0] cost_mem [ENTRIES];
    logic [COST_W-1:0] req_mem  [ENTRIES];
    logic [COST_W-1:0] acc_mem  [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;

    logic [ACT_W-1:0]   action_reg;
    logic [ENTRY_W-1:0] entry_reg;
    logic [COST_W-1:0]  cost_rd_reg;
    logic [COST_W-1:0]  req_rd_reg;
    logic [COST_W-1:0]  acc_rd_reg;
    logic [PROD_W-1:0]  prod0_reg;
    logic [PROD_W-1:0]  prod1_reg;
    logic [COST_W-1:0]  sample_reg;
    logic [COST_W-1:0]  cost_new_reg;

    logic               out_valid_reg;
    logic [COST_W-1:0]  out_cost_reg;
    logic [COST_W-1:0]  out_req_reg;
    logic [COST_W-1:0]  out_acc_reg;
    logic               out_upd_reg;

    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   in_idx;
    logic               in_range;
    logic               rd_valid;
    logic [COST_W-1:0]  cur_cost;
    logic [COST_W-1:0]  cur_req;
    logic [COST_W-1:0]  cur_acc;
    logic [COEF_W-1:0]  k_eff;
    logic [COEF_W-1:0]  a_eff;
    logic               go_update;
    logic               acc_zero;
    logic               commit;
    logic               out_free;

    logic [DIV_W-1:0]   mix_sum;
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [DVS_W-1:0]   div_divisor;
    logic [DIV_W-1:0]   div_quot;
    logic               div_busy;
    logic               div_done;

    logic [COST_W-1:0]  q_sat;
    logic [COST_W:0]    bump;
    logic [COST_W-1:0]  mix_final;

    logic [COST_W-1:0]  res_cost;
    logic [COST_W-1:0]  res_req;
    logic [COST_W-1:0]  res_acc;
    logic               res_upd;

    assign idx      = IDX_W'(entry_reg);
    assign in_idx   = IDX_W'(in_entry);
    assign in_range = {5'd0, entry_reg} < ENT_LIM;
    assign rd_valid = in_range && valid_reg[idx];
    assign cur_cost = rd_valid ? cost_rd_reg : COST_INIT;
    assign cur_req  = rd_valid ? req_rd_reg : '0;
    assign cur_acc  = rd_valid ? acc_rd_reg : '0;

    assign k_eff = (scale_reg == '0) ? COEF_W'(1) : scale_reg;
    assign a_eff = (alpha_reg > k_eff) ? k_eff : alpha_reg;

    assign acc_zero  = cur_acc == '0;
    assign go_update = in_range && (action_reg == ACT_UPDATE) && (cur_req >= threshold_reg);
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign commit    = cmd.op == OP_COMMIT;

    assign mix_sum      = DIV_W'(prod0_reg) + DIV_W'(prod1_reg);
    assign div_start    = (cmd.op == OP_DIV_RATIO) || (cmd.op == OP_DIV_MIX);
    assign div_dividend = (cmd.op == OP_DIV_MIX) ? mix_sum : DIV_W'(prod0_reg);
    assign div_divisor  = (cmd.op == OP_DIV_MIX) ? DVS_W'(k_eff) : cur_acc;

    lce_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .busy     (div_busy),
        .done     (div_done)
    );

    assign q_sat     = sat_quot(div_quot);
    assign bump      = {1'b0, q_sat} + (COST_W + 1)'(k_eff);
    assign mix_final = ((q_sat == cur_cost) && acc_zero)
                     ? (bump[COST_W] ? COST_SENTINEL : bump[COST_W-1:0])
                     : q_sat;

    always_comb
    begin
        res_cost = cur_cost;
        res_req  = cur_req;
        res_acc  = cur_acc;
        res_upd  = 1'b0;
        unique case (action_reg)
            ACT_INIT:
            begin
                res_cost = COST_INIT;
                res_req  = '0;
                res_acc  = '0;
            end
            ACT_REQUEST:
            begin
                res_req = sat_inc(cur_req);
            end
            ACT_ACCEPT:
            begin
                res_acc = sat_inc(cur_acc);
            end
            default:
            begin
                if (go_update)
                begin
                    res_cost = cost_new_reg;
                    res_req  = '0;
                    res_acc  = '0;
                    res_upd  = 1'b1;
                end
            end
        endcase
        if (!in_range)
        begin
            res_cost = '0;
            res_req  = '0;
            res_acc  = '0;
            res_upd  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= SCALE_RESET;
            alpha_reg     <= ALPHA_RESET;
            threshold_reg <= THRESHOLD_RESET;
            ceiling_reg   <= CEILING_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SCALE:     scale_reg     <= cfg_data[COEF_W-1:0];
                REG_ALPHA:     alpha_reg     <= cfg_data[COEF_W-1:0];
                REG_THRESHOLD: threshold_reg <= cfg_data;
                REG_CEILING:   ceiling_reg   <= cfg_data;
                default:       scale_reg     <= scale_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit && in_range)
            begin
                valid_reg[idx] <= 1'b1;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg  <= in_action;
            entry_reg   <= in_entry;
            cost_rd_reg <= cost_mem[in_idx];
            req_rd_reg  <= req_mem[in_idx];
            acc_rd_reg  <= acc_mem[in_idx];
        end
        case (cmd.op)
            OP_MUL_RATIO:
            begin
                prod0_reg <= PROD_W'(k_eff) * PROD_W'(cur_req);
            end
            OP_SAMPLE:
            begin
                sample_reg   <= acc_zero ? ceiling_reg : q_sat;
                cost_new_reg <= acc_zero ? ceiling_reg : q_sat;
            end
            OP_MUL_MIX:
            begin
                prod0_reg <= PROD_W'(k_eff - a_eff) * PROD_W'(cur_cost);
                prod1_reg <= PROD_W'(a_eff) * PROD_W'(sample_reg);
            end
            OP_MIX_DONE:
            begin
                cost_new_reg <= mix_final;
            end
            default:
            begin
                sample_reg <= sample_reg;
            end
        endcase
        if (commit)
        begin
            out_cost_reg <= res_cost;
            out_req_reg  <= res_req;
            out_acc_reg  <= res_acc;
            out_upd_reg  <= res_upd;
            if (in_range)
            begin
                cost_mem[idx] <= res_cost;
                req_mem[idx]  <= res_req;
                acc_mem[idx]  <= res_acc;
            end
        end
    end

    assign status.go_update    = go_update;
    assign status.acc_zero     = acc_zero;
    assign status.old_sentinel = cur_cost == COST_SENTINEL;
    assign status.div_done     = div_done;
    assign status.div_busy     = div_busy;
    assign status.out_free     = out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_acc_reg, out_req_reg, out_cost_reg};
    assign m_axis_tuser  = out_upd_reg;

endmodule

[src/lce_ctrl.sv]
// Controller state machine that sequences one request through the datapath.
// Depends on lce_pkg for the command and status types.
module lce_ctrl
    import lce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  lce_status_t status,
    output lce_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_EVAL       = 4'd1;
    localparam logic [3:0] S_MUL_RATIO  = 4'd2;
    localparam logic [3:0] S_DIV_RATIO  = 4'd3;
    localparam logic [3:0] S_WAIT_RATIO = 4'd4;
    localparam logic [3:0] S_SAMPLE     = 4'd5;
    localparam logic [3:0] S_MUL_MIX    = 4'd6;
    localparam logic [3:0] S_DIV_MIX    = 4'd7;
    localparam logic [3:0] S_WAIT_MIX   = 4'd8;
    localparam logic [3:0] S_MIX_DONE   = 4'd9;
    localparam logic [3:0] S_COMMIT     = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!status.go_update)
                begin
                    state_next = S_COMMIT;
                end
                else if (status.acc_zero)
                begin
                    state_next = S_SAMPLE;
                end
                else
                begin
                    state_next = S_MUL_RATIO;
                end
            end
            S_MUL_RATIO:
            begin
                cmd.op     = OP_MUL_RATIO;
                state_next = S_DIV_RATIO;
            end
            S_DIV_RATIO:
            begin
                cmd.op     = OP_DIV_RATIO;
                state_next = S_WAIT_RATIO;
            end
            S_WAIT_RATIO:
            begin
                if (status.div_done)
                begin
                    state_next = S_SAMPLE;
                end
            end
            S_SAMPLE:
            begin
                cmd.op     = OP_SAMPLE;
                state_next = status.old_sentinel ? S_COMMIT : S_MUL_MIX;
            end
            S_MUL_MIX:
            begin
                cmd.op     = OP_MUL_MIX;
                state_next = S_DIV_MIX;
            end
            S_DIV_MIX:
            begin
                cmd.op     = OP_DIV_MIX;
                state_next = S_WAIT_MIX;
            end
            S_WAIT_MIX:
            begin
                if (status.div_done)
                begin
                    state_next = S_MIX_DONE;
                end
            end
            S_MIX_DONE:
            begin
                cmd.op     = OP_MIX_DONE;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_COMMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_axis_tready = state_reg == S_IDLE;

endmodule

[src/link_cost_estimator.sv]
// Link cost estimator: per-neighbor request/accept counters and moving-average cost.
// Init, request, accept and below-threshold updates go from S_EVAL straight to S_COMMIT.
// An update with accepts makes two passes of the shared divider, ratio then mix; with no
// accepts only the mix pass, and with the stored cost at the 0xffff marker no mix pass.
// One request is worked on at a time; the output register frees the next accept.
// Reset (rst_n, asynchronous) clears valid bits so every entry reads as cost 256 at once.
module link_cost_estimator
    import lce_pkg::*;
#(
    parameter int ENTRIES = LCE_ENTRIES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [3:0] entry, [7:4] zero
    input  logic [1:0]  s_axis_tuser,  // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // [15:0] cost, [31:16] request_count, [47:32] accept_count
    output logic [0:0]  m_axis_tuser,  // [0] updated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    lce_cmd_t    cmd;
    lce_status_t status;

    assign cfg_ready = 1'b1;

    lce_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    lce_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_action     (s_axis_tuser),
        .in_entry      (s_axis_tdata[ENTRY_W-1:0]),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Only one request may be in flight at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request accepted while one is in flight");

    // A result is committed only when the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_COMMIT) |-> status.out_free)
        else $error("commit while output register is still held");

    // The divider is never restarted while it is iterating.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.op == OP_DIV_RATIO) || (cmd.op == OP_DIV_MIX)) |-> !status.div_busy)
        else $error("divider started while busy");

    // A new request is loaded only while no command is running in the datapath.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (cmd.op == OP_NONE) && !status.div_busy)
        else $error("request loaded during datapath activity");

endmodule

[tb/sv/lce_checker.sv]
`timescale 1ns / 1ps
// Checker for the link cost estimator: keeps its own copy of the neighbor table and
// registers, predicts every accepted request and compares each output field by field.
// Depends on lce_pkg for widths, action codes and register indexes.
module lce_checker
    import lce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          outstanding,
    output int          result_count,
    output int          recompute_count
);

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [COST_W-1:0] requests;
        logic [COST_W-1:0] accepts;
        logic              updated;
    } link_view_t;

    link_view_t        expected_links[$];
    logic [COST_W-1:0] cost_tbl [LCE_ENTRIES];
    logic [COST_W-1:0] req_tbl  [LCE_ENTRIES];
    logic [COST_W-1:0] acc_tbl  [LCE_ENTRIES];
    logic [COEF_W-1:0] scale_r;
    logic [COEF_W-1:0] alpha_r;
    logic [COST_W-1:0] threshold_r;
    logic [COST_W-1:0] ceiling_r;

    function automatic logic [COST_W-1:0] bump(input logic [COST_W-1:0] v);
        return (v == COST_SENTINEL) ? v : v + 1'b1;
    endfunction

    function automatic bit recompute_cost(input int ent);
        int unsigned     k;
        int unsigned     a;
        int unsigned     sample;
        longint unsigned mix;
        longint unsigned nc;
        if (req_tbl[ent] < threshold_r)
            return 1'b0;
        k = (scale_r == '0) ? 1 : scale_r;
        a = (alpha_r > k) ? k : alpha_r;
        if (acc_tbl[ent] != '0)
            sample = (k * req_tbl[ent]) / acc_tbl[ent];
        else
            sample = ceiling_r;
        if (sample > COST_SENTINEL)
            sample = COST_SENTINEL;
        if (cost_tbl[ent] == COST_SENTINEL)
            nc = sample;
        else
        begin
            mix = 64'(k - a) * 64'(cost_tbl[ent]) + 64'(a) * 64'(sample);
            nc  = mix / k;
            if (nc > COST_SENTINEL)
                nc = COST_SENTINEL;
            if (nc == cost_tbl[ent] && acc_tbl[ent] == '0)
            begin
                nc = nc + k;
                if (nc > COST_SENTINEL)
                    nc = COST_SENTINEL;
            end
        end
        cost_tbl[ent] = nc[COST_W-1:0];
        req_tbl[ent]  = '0;
        acc_tbl[ent]  = '0;
        return 1'b1;
    endfunction

    function automatic link_view_t next_link_state(input logic [ACT_W-1:0]   act,
                                                   input logic [ENTRY_W-1:0] ent);
        link_view_t view;
        view = '0;
        if (ent >= LCE_ENTRIES)
            return view;
        case (act)
            ACT_INIT:
            begin
                cost_tbl[ent] = COST_INIT;
                req_tbl[ent]  = '0;
                acc_tbl[ent]  = '0;
            end
            ACT_REQUEST: req_tbl[ent] = bump(req_tbl[ent]);
            ACT_ACCEPT:  acc_tbl[ent] = bump(acc_tbl[ent]);
            default:     view.updated = recompute_cost(ent);
        endcase
        view.cost     = cost_tbl[ent];
        view.requests = req_tbl[ent];
        view.accepts  = acc_tbl[ent];
        return view;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        link_view_t want;
        link_view_t got;
        int         errs;
        if (!rst_n)
        begin
            for (int i = 0; i < LCE_ENTRIES; i++)
            begin
                cost_tbl[i] = COST_INIT;
                req_tbl[i]  = '0;
                acc_tbl[i]  = '0;
            end
            scale_r         = SCALE_RESET;
            alpha_r         = ALPHA_RESET;
            threshold_r     = THRESHOLD_RESET;
            ceiling_r       = CEILING_RESET;
            expected_links.delete();
            fail_count      <= 0;
            outstanding     <= 0;
            result_count    <= 0;
            recompute_count <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SCALE:     scale_r     = cfg_data[COEF_W-1:0];
                    REG_ALPHA:     alpha_r     = cfg_data[COEF_W-1:0];
                    REG_THRESHOLD: threshold_r = cfg_data;
                    REG_CEILING:   ceiling_r   = cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                       m_axis_tuser[0]};
                if (expected_links.size() == 0)
                begin
                    $error("result with no request pending: cost %0d", got.cost);
                    errs++;
                end
                else
                begin
                    want = expected_links.pop_front();
                    if (got.cost !== want.cost)
                    begin
                        $error("cost: expected %0d, actual %0d", want.cost, got.cost);
                        errs++;
                    end
                    if (got.requests !== want.requests)
                    begin
                        $error("request_count: expected %0d, actual %0d",
                               want.requests, got.requests);
                        errs++;
                    end
                    if (got.accepts !== want.accepts)
                    begin
                        $error("accept_count: expected %0d, actual %0d",
                               want.accepts, got.accepts);
                        errs++;
                    end
                    if (got.updated !== want.updated)
                    begin
                        $error("updated: expected %0d, actual %0d", want.updated, got.updated);
                        errs++;
                    end
                end
                result_count <= result_count + 1;
                if (got.updated === 1'b1)
                    recompute_count <= recompute_count + 1;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_links.push_back(next_link_state(s_axis_tuser,
                                                         s_axis_tdata[ENTRY_W-1:0]));
            outstanding <= expected_links.size();
            fail_count  <= fail_count + errs;
        end
    end

endmodule

[tb/sv/tb_link_cost_estimator.sv]
`timescale 1ns / 1ps
// Testbench top for the link cost estimator: clock, reset, register writes and
// request stimulus under several idle and stall patterns; lce_checker does the checking.
// Depends on lce_pkg, link_cost_estimator and lce_checker.
module tb_link_cost_estimator
    import lce_pkg::*;
();

    localparam int CYCLE_LIMIT  = 4000000;
    localparam int PHASE_ITEMS  = 225;
    localparam logic [ENTRY_W-1:0] SAT_ENTRY = 4'd6;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int fail_count;
    int outstanding;
    int result_count;
    int recompute_count;
    int cycle_count = 0;
    int send_idle_pct;
    int recv_stall_pct;
    int threshold_hint;
    logic [15:0] rand_scale;

    link_cost_estimator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    lce_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .result_count    (result_count),
        .recompute_count (recompute_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d results outstanding.",
                     outstanding);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_item(input logic [ACT_W-1:0] act, input logic [ENTRY_W-1:0] ent);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, ent};
        s_axis_tuser  <= act;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic write_regs(input logic [15:0] scale, input logic [15:0] alpha,
                              input logic [15:0] thr, input logic [15:0] ceil_cost);
        drain();
        put_reg(REG_SCALE, scale);
        put_reg(REG_ALPHA, alpha);
        put_reg(REG_THRESHOLD, thr);
        put_reg(REG_CEILING, ceil_cost);
        cfg_valid <= 1'b0;
        @(posedge clk);
        threshold_hint = thr;
    endtask

    // Mostly request/accept bursts closed by an update, with stray actions mixed in.
    task automatic run_random(input int n_items);
        int                 sent;
        int                 nreq;
        int                 nacc;
        logic [ENTRY_W-1:0] ent;
        sent = 0;
        while (sent < n_items)
        begin
            ent = ENTRY_W'($urandom_range(LCE_ENTRIES - 1));
            if ($urandom_range(99) < 20)
            begin
                send_item(ACT_W'($urandom_range(3)), ent);
                sent++;
            end
            else
            begin
                if ($urandom_range(9) == 0)
                begin
                    send_item(ACT_INIT, ent);
                    sent++;
                end
                nreq = $urandom_range(threshold_hint + 3);
                nacc = $urandom_range(nreq);
                while (nreq + nacc > 0)
                begin
                    if (nacc == 0 || (nreq > 0 && $urandom_range(1) == 0))
                    begin
                        send_item(ACT_REQUEST, ent);
                        nreq--;
                    end
                    else
                    begin
                        send_item(ACT_ACCEPT, ent);
                        nacc--;
                    end
                    sent++;
                end
                send_item(ACT_UPDATE, ent);
                sent++;
            end
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = ACT_INIT;
        m_axis_tready  = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_SCALE;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        threshold_hint = THRESHOLD_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values: below-threshold update, ratio sample, no-accept sample.
        send_item(ACT_UPDATE, 4'd0);
        send_item(ACT_REQUEST, 4'd0);
        send_item(ACT_REQUEST, 4'd0);
        send_item(ACT_REQUEST, 4'd0);
        send_item(ACT_ACCEPT, 4'd0);
        send_item(ACT_UPDATE, 4'd0);
        send_item(ACT_REQUEST, 4'd15);
        send_item(ACT_REQUEST, 4'd15);
        send_item(ACT_REQUEST, 4'd15);
        send_item(ACT_UPDATE, 4'd15);
        send_item(ACT_ACCEPT, 4'd15);
        send_item(ACT_INIT, 4'd15);
        send_item(ACT_ACCEPT, 4'd9);
        send_item(ACT_UPDATE, 4'd9);
        send_item(ACT_INIT, 4'd0);
        send_item(ACT_UPDATE, 4'd10);

        // At the largest threshold an update leaves a busy entry untouched.
        write_regs(16'd256, 16'd32, 16'hffff, 16'd1024);
        for (int i = 0; i < 6; i++)
        begin
            send_item(ACT_REQUEST, SAT_ENTRY);
            send_item(ACT_ACCEPT, SAT_ENTRY);
        end
        send_item(ACT_UPDATE, SAT_ENTRY);

        write_regs(16'hfc00, 16'd1024, 16'd0, 16'hffff);
        run_random(PHASE_ITEMS);

        send_idle_pct = 87;
        write_regs(16'd0, 16'hffff, 16'd1, 16'd0);
        run_random(PHASE_ITEMS);

        send_idle_pct  = 0;
        recv_stall_pct = 87;
        write_regs(16'd1, 16'd0, 16'd2, 16'd300);
        run_random(PHASE_ITEMS);

        send_idle_pct  = 10;
        recv_stall_pct = 10;
        rand_scale     = 16'($urandom_range(1024, 1));
        write_regs(rand_scale, 16'($urandom_range(rand_scale)), 16'($urandom_range(4)),
                   16'($urandom));
        run_random(PHASE_ITEMS);

        drain();
        repeat (200) @(posedge clk);
        $display("Checked %0d results, %0d of them cost recomputes, over six register settings",
                 result_count, recompute_count);
        $display("with a maximum-threshold burst and four sender idle and receiver stall patterns.");
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[link_cost_estimator.f]
src/lce_pkg.sv
src/lce_div.sv
src/lce_datapath.sv
src/lce_ctrl.sv
src/link_cost_estimator.sv
tb/sv/lce_checker.sv
tb/sv/tb_link_cost_estimator.sv
